// File: sv/ldas_pkg.sv
// Shared types, codes and table-building functions for the log-domain add/sub core.
// No dependencies; every other file imports this package.
package ldas_pkg;

    // Operation codes carried on the opcode port
    typedef enum logic {
        OP_ADD = 1'b0,
        OP_SUB = 1'b1
    } opcode_t;

    // Control bits that travel with an item through the pipeline
    typedef struct packed {
        logic valid;
        logic op_sub;
        logic invalid;
        logic no_corr;
    } ldas_ctl_t;

    // Internal format for table generation: Q.30
    localparam int     IQ      = 30;
    localparam longint IONE    = longint'(1) << IQ;
    localparam longint LN2_Q30 = 744261118;

    // Unsigned 64-bit quotient by shift and subtract; elaboration only
    function automatic longint unsigned ldas_udiv(longint unsigned num,
                                                  longint unsigned den);
        longint unsigned q;
        logic [64:0]     rem;
        q   = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--)
        begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den})
            begin
                rem  = rem - {1'b0, den};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // e^(-32*t), t and result in Q.30, 0 <= t <= 0.5
    function automatic longint ldas_exp_neg32(longint t);
        longint          sum;
        longint unsigned term;
        longint unsigned tu;
        longint unsigned v;
        sum  = IONE;
        term = IONE;
        tu   = t;
        for (int k = 1; k <= 30; k++)
        begin
            term = ldas_udiv((term * tu) >> IQ, longint'(k));
            if ((k & 1) == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        v = sum;
        for (int k = 0; k < 5; k++)
        begin
            v = (v * v + (longint'(1) << (IQ - 1))) >> IQ;
        end
        return longint'(v);
    endfunction

    // Natural log, z in Q.30, 0 < z <= 2
    function automatic longint ldas_ln_q30(longint z_in);
        longint          z;
        longint          k;
        longint          u;
        longint          u2;
        longint          s;
        longint          p;
        longint unsigned num;
        longint unsigned den;
        z = z_in;
        k = 0;
        if (z <= 0)
            z = 1;
        while (z < IONE)
        begin
            z = z << 1;
            k = k + 1;
        end
        num = z - IONE;
        den = z + IONE;
        u   = longint'(ldas_udiv(num << IQ, den));
        num = u;
        u2  = longint'((num * num) >> IQ);
        s   = u;
        p   = u;
        for (int j = 3; j < 80; j += 2)
        begin
            num = p;
            den = u2;
            p   = longint'((num * den) >> IQ);
            s   = s + longint'(ldas_udiv(p, longint'(j)));
        end
        return 2 * s - k * LN2_Q30;
    endfunction

    // Round Q.30 to fb fraction bits, ties toward +inf
    function automatic longint ldas_to_frac(longint v, int fb);
        int sh;
        sh = IQ - fb;
        return (v + (longint'(1) << (sh - 1))) >>> sh;
    endfunction

    // Sample point t = i / (2n) in Q.30, so that d = 32 t
    function automatic longint ldas_sample_t(int n, int i);
        longint nn;
        nn = n;
        return longint'(ldas_udiv((longint'(i) << IQ) + nn, 2 * nn));
    endfunction

    // ln(1 + e^-d_i)
    function automatic longint ldas_add_entry(int n, int fb, int i);
        longint ex;
        ex = ldas_exp_neg32(ldas_sample_t(n, i));
        return ldas_to_frac(ldas_ln_q30(IONE + ex), fb);
    endfunction

    // ln(1 - e^-d_i); entry 0 sampled at half a step
    function automatic longint ldas_sub_entry(int n, int fb, int i);
        longint ex;
        longint nn;
        nn = n;
        if (i == 0)
            ex = ldas_exp_neg32(longint'(ldas_udiv(IONE + 2 * nn, 4 * nn)));
        else
            ex = ldas_exp_neg32(ldas_sample_t(n, i));
        return ldas_to_frac(ldas_ln_q30(IONE - ex), fb);
    endfunction

endpackage

// File: sv/log_domain_add_sub_core.sv
// Log-domain add/subtract (Jacobian logarithm) on Q15.16 natural logs.
// Throughput: one item per cycle while the output is not stalled by out_ready.
// Stages: difference/max, index multiply, table ROM read, interpolation multiply,
// round/add/saturate. Tables are elaboration-time constants: nothing to fill.
// Reset (rst_n, async, active low) clears all stage valid bits; payload is not reset.
// Depends on ldas_pkg, ldas_prep, ldas_lut, ldas_interp.
module log_domain_add_sub_core
    import ldas_pkg::*;
#(
    parameter int TABLE_ENTRIES = 256,
    parameter int FRAC_BITS     = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               opcode,
    input  logic signed [31:0] log_a,
    input  logic signed [31:0] log_b,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] log_result,
    output logic               invalid
);

    localparam int DW = FRAC_BITS + 4;   // bits of d below the 16.0 cutoff
    localparam int AW = $clog2(TABLE_ENTRIES + 1);
    localparam int TW = FRAC_BITS + 5;   // table sample width, signed

    // Per-stage advance: a stage loads when it is empty or its successor moves.
    // Bubbles collapse, so a stalled output still lets earlier stages fill.
    logic adv1, adv2, adv3, adv4, adv5;

    logic               s1_valid;
    logic               s4_valid;
    ldas_ctl_t          ctl2;
    ldas_ctl_t          ctl3;
    logic signed [31:0] base2;
    logic signed [31:0] base3;
    logic [AW-1:0]      idx2;
    logic [DW-1:0]      r2;
    logic [DW-1:0]      r3;
    logic signed [TW-1:0] t0_3;
    logic signed [TW-1:0] t1_3;

    assign adv5     = !out_valid || out_ready;
    assign adv4     = !s4_valid || adv5;
    assign adv3     = !ctl3.valid || adv4;
    assign adv2     = !ctl2.valid || adv3;
    assign adv1     = !s1_valid || adv2;
    assign in_ready = adv1;

    // Stages 1-2: max/difference, then index = d*N >> (FRAC_BITS+4)
    ldas_prep #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .FRAC_BITS     (FRAC_BITS)
    ) u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .opcode   (opcode),
        .log_a    (log_a),
        .log_b    (log_b),
        .adv1     (adv1),
        .adv2     (adv2),
        .s1_valid (s1_valid),
        .ctl2     (ctl2),
        .base2    (base2),
        .idx2     (idx2),
        .r2       (r2)
    );

    // Stage 3: registered read of both bracketing samples from add or sub table
    ldas_lut #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .FRAC_BITS     (FRAC_BITS)
    ) u_lut (
        .clk   (clk),
        .rst_n (rst_n),
        .adv3  (adv3),
        .ctl2  (ctl2),
        .base2 (base2),
        .idx2  (idx2),
        .r2    (r2),
        .ctl3  (ctl3),
        .base3 (base3),
        .t0_3  (t0_3),
        .t1_3  (t1_3),
        .r3    (r3)
    );

    // Stages 4-5: (t1-t0)*r, round to nearest, add base, saturate; stage 5 is the output
    ldas_interp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_interp (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv4       (adv4),
        .adv5       (adv5),
        .ctl3       (ctl3),
        .base3      (base3),
        .t0_3       (t0_3),
        .t1_3       (t1_3),
        .r3         (r3),
        .s4_valid   (s4_valid),
        .out_valid  (out_valid),
        .log_result (log_result),
        .invalid    (invalid)
    );

    // An invalid subtract always reports the most negative value
    a_invalid_min: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && invalid |-> log_result == 32'sh8000_0000)
        else $error("invalid item without most-negative result");

    // Taking the output frees every stage, so input must be ready
    a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("stall chain holds input while output drains");

    // A new result only comes from an item that sat in stage 4
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(s4_valid))
        else $error("output valid without a stage 4 item");

endmodule

// File: sv/ldas_prep.sv
// Stages 1-2: operand difference, max select, then table index and remainder.
// Depends on ldas_pkg.
module ldas_prep
    import ldas_pkg::*;
#(
    parameter int TABLE_ENTRIES = 256,
    parameter int FRAC_BITS     = 16
)
(
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     in_valid,
    input  logic                                     opcode,
    input  logic signed [31:0]                       log_a,
    input  logic signed [31:0]                       log_b,
    input  logic                                     adv1,
    input  logic                                     adv2,
    output logic                                     s1_valid,
    output ldas_ctl_t                                ctl2,
    output logic signed [31:0]                       base2,
    output logic [$clog2(TABLE_ENTRIES+1)-1:0]       idx2,
    output logic [FRAC_BITS+3:0]                     r2
);

    localparam int DW = FRAC_BITS + 4;
    localparam int AW = $clog2(TABLE_ENTRIES + 1);
    localparam int PW = DW + AW;

    ldas_ctl_t          ctl1_reg, ctl1_next;
    logic signed [31:0] base1_reg, base1_next;
    logic [DW-1:0]      d1_reg, d1_next;

    ldas_ctl_t          ctl2_reg;
    logic signed [31:0] base2_reg;
    logic [AW-1:0]      idx2_reg, idx2_next;
    logic [DW-1:0]      r2_reg, r2_next;

    logic [32:0] diff_ab;
    logic [32:0] diff_ba;
    logic [32:0] d_abs;
    logic        a_gt_b;
    logic        op_sub;
    logic        take_a;
    logic [PW-1:0] prod;

    always_comb
    begin
        diff_ab = {log_a[31], log_a} - {log_b[31], log_b};
        diff_ba = {log_b[31], log_b} - {log_a[31], log_a};
        a_gt_b  = !diff_ab[32] && (diff_ab != '0);
        op_sub  = (opcode_t'(opcode) == OP_SUB);
        take_a  = op_sub || a_gt_b;
        d_abs   = take_a ? diff_ab : diff_ba;

        ctl1_next.valid   = in_valid;
        ctl1_next.op_sub  = op_sub;
        ctl1_next.invalid = op_sub && !a_gt_b;
        ctl1_next.no_corr = (d_abs[32:DW] != '0);
        base1_next        = take_a ? log_a : log_b;
        d1_next           = d_abs[DW-1:0];
    end

    // p = d * TABLE_ENTRIES; span is a power of two, so index/remainder are slices
    always_comb
    begin
        prod      = PW'(d1_reg) * PW'(TABLE_ENTRIES);
        idx2_next = prod[PW-1:DW];
        r2_next   = prod[DW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
        end
        else
        begin
            if (adv1)
                ctl1_reg <= ctl1_next;
            if (adv2)
                ctl2_reg <= ctl1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            base1_reg <= base1_next;
            d1_reg    <= d1_next;
        end
        if (adv2)
        begin
            base2_reg <= base1_reg;
            idx2_reg  <= idx2_next;
            r2_reg    <= r2_next;
        end
    end

    assign s1_valid = ctl1_reg.valid;
    assign ctl2     = ctl2_reg;
    assign base2    = base2_reg;
    assign idx2     = idx2_reg;
    assign r2       = r2_reg;

endmodule

// File: sv/ldas_lut.sv
// Stage 3: correction table ROMs, reads the two bracketing samples.
// Depends on ldas_pkg (table-building functions).
module ldas_lut
    import ldas_pkg::*;
#(
    parameter int TABLE_ENTRIES = 256,
    parameter int FRAC_BITS     = 16
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 adv3,
    input  ldas_ctl_t                            ctl2,
    input  logic signed [31:0]                   base2,
    input  logic [$clog2(TABLE_ENTRIES+1)-1:0]   idx2,
    input  logic [FRAC_BITS+3:0]                 r2,
    output ldas_ctl_t                            ctl3,
    output logic signed [31:0]                   base3,
    output logic signed [FRAC_BITS+4:0]          t0_3,
    output logic signed [FRAC_BITS+4:0]          t1_3,
    output logic [FRAC_BITS+3:0]                 r3
);

    localparam int DW = FRAC_BITS + 4;
    localparam int AW = $clog2(TABLE_ENTRIES + 1);
    localparam int TW = FRAC_BITS + 5;

    logic signed [TW-1:0] add_rom [TABLE_ENTRIES+1];
    logic signed [TW-1:0] sub_rom [TABLE_ENTRIES+1];

    for (genvar g = 0; g <= TABLE_ENTRIES; g++)
    begin : g_rom
        localparam longint ADD_V = ldas_add_entry(TABLE_ENTRIES, FRAC_BITS, g);
        localparam longint SUB_V = ldas_sub_entry(TABLE_ENTRIES, FRAC_BITS, g);
        assign add_rom[g] = TW'(ADD_V);
        assign sub_rom[g] = TW'(SUB_V);
    end

    ldas_ctl_t            ctl3_reg;
    logic signed [31:0]   base3_reg;
    logic signed [TW-1:0] t0_reg;
    logic signed [TW-1:0] t1_reg;
    logic [DW-1:0]        r3_reg;
    logic [AW-1:0]        idx_hi;

    assign idx_hi = idx2 + AW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl3_reg <= '0;
        else if (adv3)
            ctl3_reg <= ctl2;
    end

    always_ff @(posedge clk)
    begin
        if (adv3)
        begin
            base3_reg <= base2;
            r3_reg    <= r2;
            if (ctl2.op_sub)
            begin
                t0_reg <= sub_rom[idx2];
                t1_reg <= sub_rom[idx_hi];
            end
            else
            begin
                t0_reg <= add_rom[idx2];
                t1_reg <= add_rom[idx_hi];
            end
        end
    end

    assign ctl3  = ctl3_reg;
    assign base3 = base3_reg;
    assign t0_3  = t0_reg;
    assign t1_3  = t1_reg;
    assign r3    = r3_reg;

endmodule

// File: sv/ldas_interp.sv
// Stages 4-5: interpolation multiply, rounding, final add and saturation.
// Depends on ldas_pkg (control struct).
module ldas_interp
    import ldas_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv4,
    input  logic                          adv5,
    input  ldas_ctl_t                     ctl3,
    input  logic signed [31:0]            base3,
    input  logic signed [FRAC_BITS+4:0]   t0_3,
    input  logic signed [FRAC_BITS+4:0]   t1_3,
    input  logic [FRAC_BITS+3:0]          r3,
    output logic                          s4_valid,
    output logic                          out_valid,
    output logic signed [31:0]            log_result,
    output logic                          invalid
);

    localparam int DW = FRAC_BITS + 4;
    localparam int TW = FRAC_BITS + 5;
    localparam int PW = TW + DW + 2;
    localparam int CW = TW + 2;
    localparam logic signed [PW-1:0] HALF = {{(PW-DW){1'b0}}, 1'b1, {(DW-1){1'b0}}};

    ldas_ctl_t            ctl4_reg;
    logic signed [31:0]   base4_reg;
    logic signed [TW-1:0] t0_4_reg;
    logic signed [PW-1:0] prod_reg, prod_next;
    logic signed [TW:0]   step;

    logic                 out_valid_reg;
    logic signed [31:0]   log_result_reg, log_result_next;
    logic                 invalid_reg;

    logic signed [PW-1:0] rounded;
    logic signed [CW-1:0] corr;
    logic signed [33:0]   total;

    always_comb
    begin
        step      = {t1_3[TW-1], t1_3} - {t0_3[TW-1], t0_3};
        prod_next = PW'(step) * PW'($signed({1'b0, r3}));
    end

    always_comb
    begin
        rounded = (prod_reg + HALF) >>> DW;
        corr    = CW'(rounded) + CW'(t0_4_reg);
        if (ctl4_reg.no_corr)
            corr = '0;
        total = 34'(base4_reg) + 34'(corr);
        if (ctl4_reg.invalid)
            log_result_next = 32'sh8000_0000;
        else if (total[33:31] == 3'b000 || total[33:31] == 3'b111)
            log_result_next = total[31:0];
        else if (total[33])
            log_result_next = 32'sh8000_0000;
        else
            log_result_next = 32'sh7fff_ffff;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl4_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv4)
                ctl4_reg <= ctl3;
            if (adv5)
                out_valid_reg <= ctl4_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv4)
        begin
            base4_reg <= base3;
            t0_4_reg  <= t0_3;
            prod_reg  <= prod_next;
        end
        if (adv5)
        begin
            log_result_reg <= log_result_next;
            invalid_reg    <= ctl4_reg.invalid;
        end
    end

    assign s4_valid   = ctl4_reg.valid;
    assign out_valid  = out_valid_reg;
    assign log_result = log_result_reg;
    assign invalid    = invalid_reg;

endmodule
